@@ rtl/rfd_pkg.sv @@
// Package: shared types and constants for the RPC frame deframer.
`timescale 1ns / 1ps
`default_nettype none
package rfd_pkg;
    localparam int HeaderBytes = 24;
    localparam logic [31:0] ExtMagic = 32'h4d455441;
    localparam logic [15:0] ExtVersion = 16'd1;
    localparam int QDepth = 2;

    typedef enum logic [2:0] {
        K_FRAMING = 3'd0, K_SERVICE = 3'd1, K_METHOD = 3'd2, K_ERRTEXT = 3'd3,
        K_TRACE = 3'd4, K_SERIAL = 3'd5, K_PAYLOAD = 3'd6, K_DISCARD = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        ST_BUSY = 2'd0, ST_DONE = 2'd1, ST_ERROR = 2'd2
    } t_status;

    localparam logic [2:0] CFG_MAGIC = 3'd0;
    localparam logic [2:0] CFG_VERSION = 3'd1;
    localparam logic [2:0] CFG_TYPE = 3'd2;
    localparam logic [2:0] CFG_LAYOUT = 3'd3;
    localparam logic [2:0] CFG_MAX = 3'd4;

    typedef enum logic [16:0] {
        PH_HDR      = 17'h00001,
        PH_SVC_LEN  = 17'h00002,
        PH_SVC_STR  = 17'h00004,
        PH_MTH_LEN  = 17'h00008,
        PH_MTH_STR  = 17'h00010,
        PH_ECODE    = 17'h00020,
        PH_EMSG_LEN = 17'h00040,
        PH_EMSG_STR = 17'h00080,
        PH_EXT_HDR  = 17'h00100,
        PH_EXT_WIDE = 17'h00200,
        PH_EXT_ATT  = 17'h00400,
        PH_TRC_LEN  = 17'h00800,
        PH_TRC_STR  = 17'h01000,
        PH_SER_LEN  = 17'h02000,
        PH_SER_STR  = 17'h04000,
        PH_BODY     = 17'h08000,
        PH_OPT      = 17'h10000
    } t_phase;

    typedef struct packed {
        logic [7:0]  data;
        logic [2:0]  kind;
        logic        last;
        logic [1:0]  status;
        logic [63:0] frame_id;
        logic [31:0] resp_code;
        logic [63:0] tmo_val;
        logic [31:0] attempt;
        logic [63:0] cost_val;
        logic        has_ext;
        logic        ser_default;
    } t_result;
endpackage
`default_nettype wire

@@ rtl/rfd_parser.sv @@
// Front part: per-byte frame parser producing one tagged result per byte.
`timescale 1ns / 1ps
`default_nettype none
module rfd_parser
    import rfd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_valid,
    input  wire logic [7:0]  i_byte,
    output t_result          o_result
);
    logic [31:0] r_magic, r_max;
    logic [15:0] r_version, r_type;
    logic        r_layout;

    t_phase      r_phase, n_phase;
    logic [31:0] r_cnt, n_cnt, r_meta, n_meta, r_body, n_body;
    logic [63:0] r_word, n_word, r_rid, n_rid, r_wide, n_wide;
    logic [31:0] r_ecode, n_ecode, r_att, n_att;
    logic [2:0]  r_flags, n_flags;
    logic        r_err, n_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic <= '0; r_version <= 16'd1; r_type <= '0;
            r_layout <= 1'b0; r_max <= 32'd16777216;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAGIC:   r_magic <= i_cfg_data;
                CFG_VERSION: r_version <= i_cfg_data[15:0];
                CFG_TYPE:    r_type <= i_cfg_data[15:0];
                CFG_LAYOUT:  r_layout <= i_cfg_data[0];
                CFG_MAX:     r_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic        resp, fin;
        logic [31:0] c, w, len, need;
        t_phase      tgt, nxt;
        logic        do_enter, do_str;
        n_phase = r_phase; n_cnt = r_cnt; n_meta = r_meta; n_body = r_body;
        n_word = r_word; n_rid = r_rid; n_wide = r_wide; n_ecode = r_ecode;
        n_att = r_att; n_flags = r_flags; n_err = r_err;
        resp = r_flags[2];
        o_result = '0;
        o_result.data = i_byte;
        c = '0; w = '0; len = '0; need = '0; tgt = PH_HDR; nxt = PH_HDR;
        do_enter = 1'b0; do_str = 1'b0; fin = 1'b0;
        if (r_err) begin
            o_result.kind = K_DISCARD;
            o_result.status = ST_ERROR;
        end else begin
            case (r_phase)
                PH_HDR: begin
                    if (r_cnt == '0) begin
                        n_rid = '0; n_ecode = '0; n_wide = '0; n_att = '0;
                        n_meta = '0; n_body = '0;
                        n_flags = {r_layout, 2'b00};
                        resp = r_layout;
                        n_word = {56'd0, i_byte};
                    end else begin
                        n_word = {r_word[55:0], i_byte};
                    end
                    c = r_cnt + 32'd1;
                    n_cnt = c;
                    w = n_word[31:0];
                    if (c == 32'd4 && w != r_magic) n_err = 1'b1;
                    else if (c == 32'd6 && w[15:0] != r_version) n_err = 1'b1;
                    else if (c == 32'd8 && w[15:0] != r_type) n_err = 1'b1;
                    else if (c == 32'd16) n_rid = n_word;
                    else if (c == 32'd20) begin
                        n_meta = w;
                        if (w > r_max) n_err = 1'b1;
                    end else if (c >= 32'(HeaderBytes)) begin
                        n_body = w;
                        if (w > r_max - r_meta) n_err = 1'b1;
                        else begin
                            do_enter = 1'b1;
                            tgt = resp ? PH_ECODE : PH_SVC_LEN;
                        end
                    end
                end
                PH_SVC_STR, PH_MTH_STR, PH_EMSG_STR, PH_TRC_STR, PH_SER_STR: begin
                    case (r_phase)
                        PH_SVC_STR:  o_result.kind = K_SERVICE;
                        PH_MTH_STR:  o_result.kind = K_METHOD;
                        PH_EMSG_STR: o_result.kind = K_ERRTEXT;
                        PH_TRC_STR:  o_result.kind = K_TRACE;
                        default:     o_result.kind = K_SERIAL;
                    endcase
                    if (r_meta != '0) n_meta = r_meta - 32'd1;
                    if (r_cnt != '0) n_cnt = r_cnt - 32'd1;
                    if (n_cnt == '0) begin
                        o_result.last = 1'b1;
                        do_enter = 1'b1;
                        case (r_phase)
                            PH_SVC_STR: tgt = PH_MTH_LEN;
                            PH_TRC_STR: tgt = PH_SER_LEN;
                            PH_SER_STR: tgt = PH_BODY;
                            default:    tgt = PH_OPT;
                        endcase
                    end
                end
                PH_BODY: begin
                    o_result.kind = K_PAYLOAD;
                    if (r_body != '0) n_body = r_body - 32'd1;
                    if (n_body == '0) begin
                        o_result.last = 1'b1;
                        do_enter = 1'b1; tgt = PH_BODY;
                    end
                end
                default: begin
                    if (r_meta != '0) n_meta = r_meta - 32'd1;
                    n_word = {r_word[55:0], i_byte};
                    c = r_cnt + 32'd1;
                    n_cnt = c;
                    w = n_word[31:0];
                    len = w;
                    case (r_phase)
                        PH_SVC_LEN: if (c == 32'd4) begin
                            do_str = 1'b1; tgt = PH_SVC_STR; nxt = PH_MTH_LEN;
                        end
                        PH_MTH_LEN: if (c == 32'd4) begin
                            do_str = 1'b1; tgt = PH_MTH_STR; nxt = PH_OPT;
                        end
                        PH_ECODE: if (c == 32'd4) begin
                            n_ecode = w; do_enter = 1'b1; tgt = PH_EMSG_LEN;
                        end
                        PH_EMSG_LEN: if (c == 32'd4) begin
                            do_str = 1'b1; tgt = PH_EMSG_STR; nxt = PH_OPT;
                        end
                        PH_EXT_HDR: begin
                            if (c == 32'd4 && w != ExtMagic) n_err = 1'b1;
                            else if (c == 32'd6) begin
                                if (w[15:0] != ExtVersion) n_err = 1'b1;
                                else begin
                                    n_flags[0] = 1'b1;
                                    do_enter = 1'b1; tgt = PH_EXT_WIDE;
                                end
                            end
                        end
                        PH_EXT_WIDE: if (c == 32'd8) begin
                            n_wide = n_word; do_enter = 1'b1;
                            tgt = resp ? PH_TRC_LEN : PH_EXT_ATT;
                        end
                        PH_EXT_ATT: if (c == 32'd4) begin
                            n_att = w; do_enter = 1'b1; tgt = PH_TRC_LEN;
                        end
                        PH_TRC_LEN: if (c == 32'd4) begin
                            do_str = 1'b1; tgt = PH_TRC_STR; nxt = PH_SER_LEN;
                        end
                        PH_SER_LEN: if (c == 32'd4) begin
                            if (w != n_meta) n_err = 1'b1;
                            else begin
                                if (w != '0) n_flags[1] = 1'b1;
                                do_str = 1'b1; tgt = PH_SER_STR; nxt = PH_BODY;
                            end
                        end
                        default: begin
                            do_enter = 1'b1; tgt = PH_HDR;
                        end
                    endcase
                end
            endcase

            if (do_str) begin
                if (len > n_meta) n_err = 1'b1;
                else if (len == '0) begin
                    do_enter = 1'b1; tgt = nxt;
                end else begin
                    n_phase = tgt; n_cnt = len; n_word = '0;
                end
            end
            if (do_enter) begin
                n_cnt = '0; n_word = '0;
                if (tgt == PH_OPT) tgt = (n_meta == '0) ? PH_BODY : PH_EXT_HDR;
                n_phase = tgt;
                case (tgt)
                    PH_EXT_HDR:  need = 32'd6;
                    PH_EXT_WIDE: need = 32'd8;
                    PH_SVC_LEN, PH_MTH_LEN, PH_ECODE, PH_EMSG_LEN,
                    PH_EXT_ATT, PH_TRC_LEN, PH_SER_LEN: need = 32'd4;
                    default: need = '0;
                endcase
                if (tgt == PH_BODY && n_body == '0) n_phase = PH_HDR;
                if (n_meta < need) n_err = 1'b1;
            end

            fin = (n_phase == PH_HDR) && (n_cnt == '0);
            if (n_err) o_result.status = ST_ERROR;
            else if (fin) begin
                o_result.status = ST_DONE;
                o_result.frame_id = n_rid;
                if (resp) begin
                    o_result.resp_code = n_ecode;
                    o_result.cost_val = n_wide;
                end else begin
                    o_result.tmo_val = n_wide;
                    o_result.attempt = n_att;
                end
                o_result.has_ext = n_flags[0];
                o_result.ser_default = ~n_flags[1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR; r_cnt <= '0; r_meta <= '0; r_body <= '0;
            r_word <= '0; r_rid <= '0; r_wide <= '0; r_ecode <= '0;
            r_att <= '0; r_flags <= '0; r_err <= 1'b0;
        end else if (i_valid) begin
            r_phase <= n_phase; r_cnt <= n_cnt; r_meta <= n_meta; r_body <= n_body;
            r_word <= n_word; r_rid <= n_rid; r_wide <= n_wide; r_ecode <= n_ecode;
            r_att <= n_att; r_flags <= n_flags; r_err <= n_err;
        end
    end
endmodule
`default_nettype wire

@@ rtl/rfd_queue.sv @@
// Back part: small result queue between the parser and the output channel.
`timescale 1ns / 1ps
`default_nettype none
module rfd_queue
    import rfd_pkg::*;
#(
    parameter int Depth = QDepth
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    output logic         o_full,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_result      o_data
);
    localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;
    t_result        r_mem [Depth];
    logic [Aw-1:0]  r_wp, r_rp;
    logic [Aw:0]    r_count;
    logic           pop;

    assign pop = o_valid && !i_stall;
    assign o_valid = (r_count != '0);
    assign o_full = (r_count == (Aw+1)'(Depth));
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_count <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == Aw'(Depth - 1)) ? '0 : r_wp + 1'b1;
            if (pop) r_rp <= (r_rp == Aw'(Depth - 1)) ? '0 : r_rp + 1'b1;
            r_count <= r_count + (Aw+1)'(i_push) - (Aw+1)'(pop);
        end
    end
endmodule
`default_nettype wire

@@ rtl/rpc_frame_deframer_top.sv @@
// Top level: RPC frame deframer, parser front end feeding a result queue.
//   channel | direction | handshake        | payload
//   in      | input     | i_valid/o_stall  | i_data_byte
//   out     | output    | o_valid/i_stall  | o_out_byte .. o_serializer_default
//   cfg     | input     | i_cfg_we         | i_cfg_index, i_cfg_data
// One byte per cycle while o_stall is low; each byte is parsed in the cycle it is accepted.
// Each result is written into a result queue (two entries by default) when its byte is accepted.
// o_stall rises only while the queue is full; the input side runs freely otherwise.
// Reset is synchronous; errors stay sticky until reset.
`timescale 1ns / 1ps
`default_nettype none
module rpc_frame_deframer_top
    import rfd_pkg::*;
#(
    parameter int QueueDepth = QDepth
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_out_byte,
    output logic [2:0]       o_byte_kind,
    output logic             o_field_last,
    output logic [1:0]       o_frame_status,
    output logic [63:0]      o_request_id,
    output logic [31:0]      o_error_code,
    output logic [63:0]      o_timeout_ms,
    output logic [31:0]      o_attempt,
    output logic [63:0]      o_server_cost_us,
    output logic             o_has_extension,
    output logic             o_serializer_default
);
    t_result res, q;
    logic    full, acc;

    assign o_stall = full;
    assign acc = i_valid && !full;

    rfd_parser u_parser (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_valid(acc), .i_byte(i_data_byte), .o_result(res)
    );

    rfd_queue #(.Depth(QueueDepth)) u_queue (
        .i_clk, .i_rst_n, .i_push(acc), .i_data(res), .o_full(full),
        .o_valid, .i_stall, .o_data(q)
    );

    assign o_out_byte = q.data;
    assign o_byte_kind = q.kind;
    assign o_field_last = q.last;
    assign o_frame_status = q.status;
    assign o_request_id = q.frame_id;
    assign o_error_code = q.resp_code;
    assign o_timeout_ms = q.tmo_val;
    assign o_attempt = q.attempt;
    assign o_server_cost_us = q.cost_val;
    assign o_has_extension = q.has_ext;
    assign o_serializer_default = q.ser_default;
endmodule
`default_nettype wire

@@ rtl/rfd_checker.sv @@
// Port-level checker for the RPC frame deframer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rfd_checker
    import rfd_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic       i_valid,
    input wire logic       o_stall,
    input wire logic [1:0] o_frame_status,
    input wire logic [2:0] o_byte_kind,
    input wire logic [7:0] o_out_byte
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte))
        else $error("stalled item changed");
    a_discard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_byte_kind == K_DISCARD |-> o_frame_status == ST_ERROR)
        else $error("discarded byte without error status");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_frame_status != 2'd3)
        else $error("bad status code");
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_valid)
        else $error("accepted byte gave no result");
endmodule

bind rpc_frame_deframer_top rfd_checker u_rfd_checker (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .i_valid, .o_stall,
    .o_frame_status, .o_byte_kind, .o_out_byte
);
`default_nettype wire

@@ tb/sv/tb_rpc_frame_deframer_top.sv @@
// Testbench: RPC frame deframer stream checks against a byte-level frame parser model.
`timescale 1ns / 1ps
module tb_rpc_frame_deframer_top;
    import rfd_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_out_byte;
    logic [2:0]  o_byte_kind;
    logic        o_field_last;
    logic [1:0]  o_frame_status;
    logic [63:0] o_request_id;
    logic [31:0] o_error_code;
    logic [63:0] o_timeout_ms;
    logic [31:0] o_attempt;
    logic [63:0] o_server_cost_us;
    logic        o_has_extension;
    logic        o_serializer_default;

    rpc_frame_deframer_top DUT (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // register copies
    logic [31:0] cfg_magic = '0;
    logic [15:0] cfg_version = 16'd1;
    logic [15:0] cfg_type = '0;
    logic        cfg_layout = 1'b0;
    logic [31:0] cfg_max = 32'd16777216;

    // parser state
    t_phase      ph = PH_HDR;
    logic [31:0] fcnt = '0, mleft = '0, bleft = '0, ecode = '0, att = '0;
    logic [63:0] acc = '0, rid = '0, wide = '0;
    logic        f_ext = 0, f_serne = 0, f_resp = 0, err = 0;

    logic [7:0] tx_bytes[$];
    t_result    byte_results[$];
    int         errors = 0;
    bit         no_idle = 0, hold_go = 0, hold_done = 0;
    int         hold_cnt = 0;

    function automatic void go(t_phase p);
        logic [31:0] need;
        need = 0;
        ph = p;
        fcnt = 0;
        acc = 0;
        case (p)
            PH_SVC_LEN, PH_MTH_LEN, PH_ECODE, PH_EMSG_LEN, PH_EXT_ATT, PH_TRC_LEN,
            PH_SER_LEN: need = 4;
            PH_EXT_HDR: need = 6;
            PH_EXT_WIDE: need = 8;
            PH_OPT: begin
                go(mleft == 0 ? PH_BODY : PH_EXT_HDR);
                return;
            end
            PH_BODY: begin
                if (bleft == 0) ph = PH_HDR;
                return;
            end
            default: return;
        endcase
        if (mleft < need) err = 1;
    endfunction

    function automatic void go_str(t_phase p, logic [31:0] len, t_phase nxt);
        if (len > mleft) begin
            err = 1;
            return;
        end
        if (len == 0) begin
            go(nxt);
            return;
        end
        ph = p;
        fcnt = len;
        acc = 0;
    endfunction

    function automatic t_result predict_byte(input logic [7:0] b);
        t_result r;
        logic [31:0] c, w;
        logic resp;
        r = '0;
        r.data = b;
        resp = f_resp;
        if (err) begin
            r.kind = K_DISCARD;
            r.status = ST_ERROR;
            return r;
        end
        case (ph)
            PH_HDR: begin
                if (fcnt == 0) begin
                    rid = 0; ecode = 0; wide = 0; att = 0;
                    mleft = 0; bleft = 0; acc = 0;
                    f_ext = 0; f_serne = 0; f_resp = cfg_layout; resp = cfg_layout;
                end
                acc = {acc[55:0], b};
                fcnt = fcnt + 1;
                c = fcnt;
                w = acc[31:0];
                if (c == 4 && w != cfg_magic) err = 1;
                else if (c == 6 && w[15:0] != cfg_version) err = 1;
                else if (c == 8 && w[15:0] != cfg_type) err = 1;
                else if (c == 16) rid = acc;
                else if (c == 20) begin
                    mleft = w;
                    if (w > cfg_max) err = 1;
                end else if (c >= HeaderBytes) begin
                    bleft = w;
                    if (w > cfg_max - mleft) err = 1;
                    else go(resp ? PH_ECODE : PH_SVC_LEN);
                end
            end
            PH_SVC_STR, PH_MTH_STR, PH_EMSG_STR, PH_TRC_STR, PH_SER_STR: begin
                r.kind = ph == PH_SVC_STR ? K_SERVICE : ph == PH_MTH_STR ? K_METHOD :
                         ph == PH_EMSG_STR ? K_ERRTEXT : ph == PH_TRC_STR ? K_TRACE :
                         K_SERIAL;
                if (mleft != 0) mleft = mleft - 1;
                if (fcnt != 0) fcnt = fcnt - 1;
                if (fcnt == 0) begin
                    r.last = 1;
                    if (ph == PH_SVC_STR) go(PH_MTH_LEN);
                    else if (ph == PH_TRC_STR) go(PH_SER_LEN);
                    else if (ph == PH_SER_STR) go(PH_BODY);
                    else go(PH_OPT);
                end
            end
            PH_BODY: begin
                r.kind = K_PAYLOAD;
                if (bleft != 0) bleft = bleft - 1;
                if (bleft == 0) begin
                    r.last = 1;
                    go(PH_BODY);
                end
            end
            default: begin
                if (mleft != 0) mleft = mleft - 1;
                acc = {acc[55:0], b};
                fcnt = fcnt + 1;
                c = fcnt;
                w = acc[31:0];
                case (ph)
                    PH_SVC_LEN: if (c == 4) go_str(PH_SVC_STR, w, PH_MTH_LEN);
                    PH_MTH_LEN: if (c == 4) go_str(PH_MTH_STR, w, PH_OPT);
                    PH_ECODE: if (c == 4) begin
                        ecode = w;
                        go(PH_EMSG_LEN);
                    end
                    PH_EMSG_LEN: if (c == 4) go_str(PH_EMSG_STR, w, PH_OPT);
                    PH_EXT_HDR: begin
                        if (c == 4 && w != ExtMagic) err = 1;
                        else if (c == 6) begin
                            if (w[15:0] != ExtVersion) err = 1;
                            else begin
                                f_ext = 1;
                                go(PH_EXT_WIDE);
                            end
                        end
                    end
                    PH_EXT_WIDE: if (c == 8) begin
                        wide = acc;
                        go(resp ? PH_TRC_LEN : PH_EXT_ATT);
                    end
                    PH_EXT_ATT: if (c == 4) begin
                        att = w;
                        go(PH_TRC_LEN);
                    end
                    PH_TRC_LEN: if (c == 4) go_str(PH_TRC_STR, w, PH_SER_LEN);
                    PH_SER_LEN: if (c == 4) begin
                        if (w != mleft) err = 1;
                        else begin
                            if (w != 0) f_serne = 1;
                            go_str(PH_SER_STR, w, PH_BODY);
                        end
                    end
                    default: go(PH_HDR);
                endcase
            end
        endcase
        if (err) r.status = ST_ERROR;
        else if (ph == PH_HDR && fcnt == 0) begin
            r.status = ST_DONE;
            r.frame_id = rid;
            if (resp) begin
                r.resp_code = ecode;
                r.cost_val = wide;
            end else begin
                r.tmo_val = wide;
                r.attempt = att;
            end
            r.has_ext = f_ext;
            r.ser_default = !f_serne;
        end
        return r;
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (i_valid && !o_stall)
            byte_results.insert(byte_results.size(), predict_byte(i_data_byte));
        if (!i_valid || !o_stall) begin
            if (tx_bytes.size() != 0 && (no_idle || $urandom_range(99) >= 9)) begin
                i_valid <= 1'b1;
                i_data_byte <= tx_bytes.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (hold_go && !hold_done) begin
            i_stall <= 1'b1;
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == 300) hold_done <= 1;
        end else begin
            i_stall <= !no_idle && $urandom_range(99) < 9;
        end
    end

    task automatic chk(string nm, logic [63:0] e, logic [63:0] a);
        if (e !== a) begin
            $error("%s: expected %0h, got %0h", nm, e, a);
            errors++;
        end
    endtask

    // monitor
    always @(posedge i_clk) begin
        t_result e;
        if (o_valid && !i_stall) begin
            if (byte_results.size() == 0) begin
                $error("result item with nothing expected");
                errors++;
            end else begin
                e = byte_results.pop_front();
                chk("o_out_byte", e.data, o_out_byte);
                chk("o_byte_kind", e.kind, o_byte_kind);
                chk("o_field_last", e.last, o_field_last);
                chk("o_frame_status", e.status, o_frame_status);
                chk("o_request_id", e.frame_id, o_request_id);
                chk("o_error_code", e.resp_code, o_error_code);
                chk("o_timeout_ms", e.tmo_val, o_timeout_ms);
                chk("o_attempt", e.attempt, o_attempt);
                chk("o_server_cost_us", e.cost_val, o_server_cost_us);
                chk("o_has_extension", e.has_ext, o_has_extension);
                chk("o_serializer_default", e.ser_default, o_serializer_default);
            end
        end
    end

    task automatic put_n(logic [63:0] v, int n);
        for (int i = n - 1; i >= 0; i--) tx_bytes.insert(tx_bytes.size(), v[i*8 +: 8]);
    endtask

    task automatic put_str(int n, int fill);
        for (int i = 0; i < n; i++)
            tx_bytes.insert(tx_bytes.size(), fill < 0 ? 8'($urandom) : 8'(fill));
    endtask

    // s1/s2: service/method or (unused)/message lengths; ext 0 means none
    task automatic push_frame(int s1, int s2, int trc, int ser, int body, bit ext, int fill,
                              logic [63:0] id, logic [63:0] wv, logic [31:0] av);
        int meta;
        meta = cfg_layout ? 8 + s2 : 8 + s1 + s2;
        if (ext) meta += 6 + 8 + (cfg_layout ? 0 : 4) + 8 + trc + ser;
        put_n(cfg_magic, 4);
        put_n(cfg_version, 2);
        put_n(cfg_type, 2);
        put_n(id, 8);
        put_n(meta, 4);
        put_n(body, 4);
        if (cfg_layout) begin
            put_n(av, 4);
            put_n(s2, 4);
            put_str(s2, fill);
        end else begin
            put_n(s1, 4);
            put_str(s1, fill);
            put_n(s2, 4);
            put_str(s2, fill);
        end
        if (ext) begin
            put_n(ExtMagic, 4);
            put_n(ExtVersion, 2);
            put_n(wv, 8);
            if (!cfg_layout) put_n(av, 4);
            put_n(trc, 4);
            put_str(trc, fill);
            put_n(ser, 4);
            put_str(ser, fill);
        end
        put_str(body, fill);
    endtask

    task automatic rand_frame();
        push_frame($urandom_range(6), $urandom_range(6), $urandom_range(6),
                   $urandom_range(6), $urandom_range(3) == 0 ? 0 : $urandom_range(8),
                   $urandom_range(1), -1, {$urandom, $urandom}, {$urandom, $urandom},
                   $urandom);
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [31:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        case (idx)
            CFG_MAGIC: cfg_magic = v;
            CFG_VERSION: cfg_version = v[15:0];
            CFG_TYPE: cfg_type = v[15:0];
            CFG_LAYOUT: cfg_layout = v[0];
            CFG_MAX: cfg_max = v;
            default: ;
        endcase
    endtask

    task automatic set_all(logic [31:0] m, logic [15:0] v, logic [15:0] t, bit l,
                           logic [31:0] mx);
        write_cfg(CFG_MAGIC, m);
        write_cfg(CFG_VERSION, {16'($urandom), v});
        write_cfg(CFG_TYPE, {16'($urandom), t});
        write_cfg(CFG_LAYOUT, {31'($urandom), l});
        write_cfg(CFG_MAX, mx);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (tx_bytes.size() != 0 || i_valid || byte_results.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    initial begin
        int st, en;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_all('0, '0, '0, 0, 32'hffffffff);
        push_frame(0, 0, 0, 0, 0, 0, 0, '0, '0, '0);
        push_frame(6, 6, 6, 6, 8, 1, 8'hff, '1, '1, '1);
        push_frame(1, 0, 0, 0, 1, 1, -1, 64'h0123456789abcdef, 64'd5, 32'd2);
        push_frame(0, 3, 4, 0, 0, 1, 8'h00, '0, '0, '0);
        drain();

        set_all('1, '1, '1, 1, 32'd66);
        push_frame(0, 0, 0, 0, 0, 0, 0, '0, '0, '0);
        push_frame(0, 6, 6, 6, 8, 1, 8'hff, '1, '1, '1);
        push_frame(0, 2, 0, 3, 0, 1, -1, '1, 64'd9, 32'hdeadbeef);
        push_frame(0, 0, 0, 0, 5, 0, -1, 64'd7, '0, 32'd1);
        drain();

        for (int p = 0; p < 3; p++) begin
            set_all($urandom, $urandom, $urandom, $urandom_range(1),
                    $urandom_range(1) ? 32'hffffffff : $urandom_range(66, 5000));
            if (p == 1) hold_go = 1;
            no_idle = p == 2;
            for (int f = 0; f < (p == 2 ? 2 : 1); f++) rand_frame();
            drain();
        end
        no_idle = 0;

        // final: one frame with a corrupted byte; any error it raises sticks for the rest of the run
        set_all($urandom, $urandom, $urandom, $urandom_range(1),
                $urandom_range(3) == 0 ? 32'd0 : $urandom_range(8, 80));
        st = tx_bytes.size();
        rand_frame();
        en = tx_bytes.size();
        st = $urandom_range(st, en - 1);
        tx_bytes[st] = tx_bytes[st] ^ 8'($urandom_range(1, 255));
        put_str(8, -1);
        drain();

        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end
endmodule
